// ===== hw/rtl/cebs_pkg.sv =====
// ----------------------------------------------------------------------------
// cebs_pkg
// Shared widths, codes and command/status types of the ellipse brush scanner.
// ----------------------------------------------------------------------------
package cebs_pkg;

	localparam int DIM_W    = 13;
	localparam int COORD_W  = 24;
	localparam int TS_W     = 24;
	localparam int CTR_W    = 14;
	localparam int AXIS_W   = 13;
	localparam int QUO_W    = 14;
	localparam int PROD_W   = COORD_W + DIM_W;
	localparam int COLOUR_W = 32;
	localparam int ADDR_W   = 24;
	localparam int PIX_W    = 12;
	localparam int SQ_AX_W  = 2 * AXIS_W;
	localparam int SQ_D_W   = 2 * CTR_W;
	localparam int TERM_W   = SQ_D_W + SQ_AX_W;
	localparam int RHS_W    = 2 * SQ_AX_W;
	localparam int REG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 88;

	localparam logic [DIM_W-1:0]  MAX_DIM    = 13'd4096;
	localparam logic [CTR_W-1:0]  CENTER_SAT = 14'd16383;
	localparam logic [AXIS_W-1:0] AXIS_SAT   = 13'd8191;

	localparam logic [DIM_W-1:0] WIDTH_RESET   = 13'd512;
	localparam logic [DIM_W-1:0] HEIGHT_RESET  = 13'd512;
	localparam logic [TS_W-1:0]  TERRAIN_RESET = 24'd65536;

	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_WIDTH   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_TERRAIN = 2'd2;

	typedef enum logic [1:0] {
		OP_CX,
		OP_CY,
		OP_AW,
		OP_AH
	} op_t;

	typedef struct packed {
		logic load_start;
		logic mul_en;
		logic div_go;
		logic div_store;
		logic check;
		logic square;
		logic rhs;
		logic adv_s1;
		logic adv_s2;
		logic adv_fin;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic ts_zero;
		logic div_done;
		logic reject;
		logic out_free;
	} status_t;

endpackage

// ===== hw/rtl/cebs_div.sv =====
// ----------------------------------------------------------------------------
// cebs_div
// Restoring divider, one quotient bit per cycle, with overflow flag for
// quotients that do not fit QUO_W bits.
// ----------------------------------------------------------------------------
module cebs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [cebs_pkg::PROD_W-1:0]   dividend,
	input  logic [cebs_pkg::TS_W-1:0]     divisor,
	output logic                          done,
	output logic                          ovf,
	output logic [cebs_pkg::QUO_W-1:0]    quotient
);
	import cebs_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

	logic [TS_W-1:0]  rem_q;
	logic [QUO_W-1:0] dvd_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ovf_q;
	logic [TS_W:0]    trial;
	logic             fits;

	assign trial = {rem_q, dvd_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			ovf_q <= {1'b0, dividend} >= {divisor, QUO_W'(0)};
			rem_q <= TS_W'(dividend[PROD_W-1:QUO_W]);
			dvd_q <= dividend[QUO_W-1:0];
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? TS_W'(trial - {1'b0, divisor}) : trial[TS_W-1:0];
			dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign ovf      = ovf_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/cebs_ctrl.sv =====
// ----------------------------------------------------------------------------
// cebs_ctrl
// Sequencer: start set-up (scale, divide, clip, square) and the advance steps.
// ----------------------------------------------------------------------------
module cebs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tuser,
	output logic              s_tready,
	input  cebs_pkg::status_t sts,
	output cebs_pkg::cmd_t    cmd
);
	import cebs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_CHECK,
		ST_SQUARE,
		ST_RHS,
		ST_ADV_S1,
		ST_ADV_S2,
		ST_ADV_FIN
	} state_t;

	state_t state_q;
	op_t    op_q;
	logic   accept;

	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd            = '0;
		cmd.op         = op_q;
		cmd.load_start = accept && s_tuser == CMD_START;
		cmd.mul_en     = state_q == ST_MUL;
		cmd.div_go     = state_q == ST_DIV_GO;
		cmd.div_store  = state_q == ST_DIV_WAIT && sts.div_done;
		cmd.check      = state_q == ST_CHECK;
		cmd.square     = state_q == ST_SQUARE;
		cmd.rhs        = state_q == ST_RHS;
		cmd.adv_s1     = state_q == ST_ADV_S1;
		cmd.adv_s2     = state_q == ST_ADV_S2;
		cmd.adv_fin    = state_q == ST_ADV_FIN && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_CX;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == CMD_ADVANCE) begin
							state_q <= ST_ADV_S1;
						end else if (!sts.ts_zero) begin
							state_q <= ST_MUL;
							op_q    <= OP_CX;
						end
					end
				end
				ST_MUL:    state_q <= ST_DIV_GO;
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (sts.div_done) begin
						case (op_q)
							OP_CX:   begin op_q <= OP_CY; state_q <= ST_MUL; end
							OP_CY:   begin op_q <= OP_AW; state_q <= ST_MUL; end
							OP_AW:   begin op_q <= OP_AH; state_q <= ST_MUL; end
							default: state_q <= ST_CHECK;
						endcase
					end
				end
				ST_CHECK:  state_q <= sts.reject ? ST_IDLE : ST_SQUARE;
				ST_SQUARE: state_q <= ST_RHS;
				ST_RHS:    state_q <= ST_IDLE;
				ST_ADV_S1: state_q <= ST_ADV_S2;
				ST_ADV_S2: state_q <= ST_ADV_FIN;
				ST_ADV_FIN: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/cebs_dp.sv =====
// ----------------------------------------------------------------------------
// cebs_dp
// Datapath: registers, scaling multiplier and divider, clip logic, ellipse
// test pipeline and the result register.
// ----------------------------------------------------------------------------
module cebs_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [cebs_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [cebs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [cebs_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  cebs_pkg::cmd_t                    cmd,
	output cebs_pkg::status_t                 sts,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [cebs_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                              m_tlast
);
	import cebs_pkg::*;

	function automatic logic [CTR_W-1:0] clip_lo(logic [CTR_W-1:0] c, logic [AXIS_W-1:0] a);
		return (c < CTR_W'(a)) ? '0 : c - CTR_W'(a);
	endfunction

	function automatic logic [DIM_W-1:0] clip_hi(logic [CTR_W-1:0] c, logic [AXIS_W-1:0] a,
	                                             logic [DIM_W-1:0] dim);
		logic [CTR_W:0] s;
		s = {1'b0, c} + (CTR_W + 1)'(a);
		return (s > (CTR_W + 1)'(dim)) ? dim : s[DIM_W-1:0];
	endfunction

	logic [DIM_W-1:0]    w_q, h_q, w_eff, h_eff;
	logic [TS_W-1:0]     ts_q;
	logic [COORD_W-1:0]  in_cx_q, in_cz_q, in_r_q;
	logic [COLOUR_W-1:0] colour_q;
	logic [PROD_W-1:0]   prod_q;
	logic [CTR_W-1:0]    cx_q, cy_q;
	logic [AXIS_W-1:0]   aw_q, ah_q;
	logic [SQ_AX_W-1:0]  aw2_q, ah2_q;
	logic [RHS_W-1:0]    rhs_q;
	logic [DIM_W-1:0]    col_q, row_q;
	logic                active_q;
	logic [SQ_D_W-1:0]   dx2_s1, dy2_s1;
	logic [TERM_W-1:0]   t1_s2, t2_s2;
	logic [ADDR_W-1:0]   addr_s2;

	logic                out_valid_q, out_we_q, out_sv_q, out_last_q;
	logic [PIX_W-1:0]    out_x_q, out_y_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [COLOUR_W-1:0] out_val_q;

	logic [COORD_W-1:0]  mul_v;
	logic [DIM_W-1:0]    mul_d;
	logic                div_done, div_ovf;
	logic [QUO_W-1:0]    div_quo;
	logic [CTR_W-1:0]    left, top, col_w, row_w, dx, dy;
	logic [DIM_W-1:0]    right, bottom;
	logic                reject, in_ellipse, row_end, last;
	logic                out_free;

	assign w_eff = (w_q > MAX_DIM) ? MAX_DIM : w_q;
	assign h_eff = (h_q > MAX_DIM) ? MAX_DIM : h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q  <= WIDTH_RESET;
			h_q  <= HEIGHT_RESET;
			ts_q <= TERRAIN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:   w_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT:  h_q  <= cfg_data[DIM_W-1:0];
				REG_TERRAIN: ts_q <= cfg_data[TS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cmd.op)
			OP_CX:   begin mul_v = in_cx_q; mul_d = w_eff; end
			OP_CY:   begin mul_v = in_cz_q; mul_d = h_eff; end
			OP_AW:   begin mul_v = in_r_q;  mul_d = w_eff; end
			default: begin mul_v = in_r_q;  mul_d = h_eff; end
		endcase
	end

	cebs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (prod_q),
		.divisor  (ts_q),
		.done     (div_done),
		.ovf      (div_ovf),
		.quotient (div_quo)
	);

	assign left   = clip_lo(cx_q, aw_q);
	assign top    = clip_lo(cy_q, ah_q);
	assign right  = clip_hi(cx_q, aw_q, w_eff);
	assign bottom = clip_hi(cy_q, ah_q, h_eff);
	assign reject = aw_q == '0 || ah_q == '0 || left >= CTR_W'(w_eff) ||
	                top >= CTR_W'(h_eff) || right == '0 || bottom == '0;

	assign col_w      = CTR_W'(col_q);
	assign row_w      = CTR_W'(row_q);
	assign dx         = (col_w > cx_q) ? col_w - cx_q : cx_q - col_w;
	assign dy         = (row_w > cy_q) ? row_w - cy_q : cy_q - row_w;
	assign in_ellipse = ({1'b0, t1_s2} + {1'b0, t2_s2}) < (TERM_W + 1)'(rhs_q);
	assign row_end    = row_w + 1'b1 >= CTR_W'(bottom);
	assign last       = row_end && (col_w + 1'b1 >= CTR_W'(right));

	always_ff @(posedge clk) begin
		if (cmd.load_start) begin
			in_cx_q  <= s_tdata[COORD_W-1:0];
			in_cz_q  <= s_tdata[2*COORD_W-1:COORD_W];
			in_r_q   <= s_tdata[3*COORD_W-1:2*COORD_W];
			colour_q <= s_tdata[3*COORD_W+COLOUR_W-1:3*COORD_W];
		end
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(mul_v) * PROD_W'(mul_d);
		end
		if (cmd.div_store) begin
			case (cmd.op)
				OP_CX:   cx_q <= div_ovf ? CENTER_SAT : div_quo;
				OP_CY:   cy_q <= div_ovf ? CENTER_SAT : div_quo;
				OP_AW:   aw_q <= (div_ovf || div_quo > QUO_W'(AXIS_SAT)) ?
				                 AXIS_SAT : div_quo[AXIS_W-1:0];
				default: ah_q <= (div_ovf || div_quo > QUO_W'(AXIS_SAT)) ?
				                 AXIS_SAT : div_quo[AXIS_W-1:0];
			endcase
		end
		if (cmd.square) begin
			aw2_q <= SQ_AX_W'(aw_q) * SQ_AX_W'(aw_q);
			ah2_q <= SQ_AX_W'(ah_q) * SQ_AX_W'(ah_q);
		end
		if (cmd.rhs) begin
			rhs_q <= RHS_W'(aw2_q) * RHS_W'(ah2_q);
		end
		if (cmd.adv_s1) begin
			dx2_s1 <= SQ_D_W'(dx) * SQ_D_W'(dx);
			dy2_s1 <= SQ_D_W'(dy) * SQ_D_W'(dy);
		end
		if (cmd.adv_s2) begin
			t1_s2   <= TERM_W'(dx2_s1) * TERM_W'(ah2_q);
			t2_s2   <= TERM_W'(dy2_s1) * TERM_W'(aw2_q);
			addr_s2 <= ADDR_W'(SQ_AX_W'(row_q) * SQ_AX_W'(w_eff) + SQ_AX_W'(col_q));
		end
		if (cmd.check && !reject) begin
			col_q <= left[DIM_W-1:0];
			row_q <= top[DIM_W-1:0];
		end else if (cmd.adv_fin && active_q && !last) begin
			if (row_end) begin
				row_q <= top[DIM_W-1:0];
				col_q <= col_q + 1'b1;
			end else begin
				row_q <= row_q + 1'b1;
			end
		end
		if (cmd.adv_fin) begin
			out_x_q    <= active_q ? col_q[PIX_W-1:0] : '0;
			out_y_q    <= active_q ? row_q[PIX_W-1:0] : '0;
			out_addr_q <= active_q ? addr_s2 : '0;
			out_val_q  <= (active_q && in_ellipse) ? colour_q : '0;
			out_we_q   <= active_q && in_ellipse;
			out_sv_q   <= active_q;
			out_last_q <= active_q && last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_start) begin
				active_q <= 1'b0;
			end else if (cmd.check && !reject) begin
				active_q <= 1'b1;
			end else if (cmd.adv_fin && last) begin
				active_q <= 1'b0;
			end
			if (cmd.adv_fin) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_free = !out_valid_q || m_tready;

	assign sts.ts_zero  = ts_q == '0;
	assign sts.div_done = div_done;
	assign sts.reject   = reject;
	assign sts.out_free = out_free;

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {6'b0, out_sv_q, out_we_q, out_val_q, out_addr_q, out_y_q, out_x_q};

endmodule

// ===== hw/rtl/clipped_ellipse_brush_scan_core.sv =====
// ----------------------------------------------------------------------------
// clipped_ellipse_brush_scan_core
// Scans the texels of a clipped elliptical brush and flags those inside it.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser is the command (start or advance), tdata the brush
// centre, radius and colour. A start produces no result; it scales the brush
// to texels with four sequential divisions (one quotient bit per cycle in a
// shared divider), clips the box and, unless it is rejected, squares the
// semi-axes, with s_tready low throughout (skipped when terrain_size is zero).
// An advance produces one texel item on m_*: it runs through a three-step
// squaring and multiply path; m_tvalid rises when its last step fills the
// output register, and no new item is taken before that step is through.
// Advances while no stamp is active return an all-zero item.
// The output register holds a finished item while m_tready is low; the next
// item waits in its last step until that register is free.
// Configuration writes (cfg_index 0 width, 1 height, 2 terrain size) are
// always taken and belong between items. Reset clears the stamp, the output
// valid flag and restores the register defaults; no memory needs clearing.
// ----------------------------------------------------------------------------
module clipped_ellipse_brush_scan_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cebs_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [cebs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// center_x[23:0], center_z[47:24], radius[71:48], paint_colour[103:72]
	input  logic [cebs_pkg::IN_TDATA_W-1:0]   s_tdata,
	// cmd[0]
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// pixel_x[11:0], pixel_y[23:12], pixel_address[47:24], pixel_value[79:48],
	// write_enable[80], scan_valid[81], zero pad[87:82]
	output logic [cebs_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                              m_tlast
);
	import cebs_pkg::*;

	cmd_t    cmd;
	status_t sts;

	assign cfg_ready = 1'b1;

	cebs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cebs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== hw/rtl/cebs_checker.sv =====
// ----------------------------------------------------------------------------
// cebs_checker
// Port-level checks of the brush scanner, bound to the top level.
// ----------------------------------------------------------------------------
module cebs_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [cebs_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input logic                              m_tlast
);
	import cebs_pkg::*;

	localparam int WE_BIT = 80;
	localparam int SV_BIT = 81;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_adv_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == CMD_ADVANCE && !m_tvalid |-> ##4 m_tvalid)
		else $error("advance item gave no result after four cycles");

	a_busy_before_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without an item in flight");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tlast || m_tdata[WE_BIT]) |-> m_tdata[SV_BIT])
		else $error("write or last flag on a non-candidate texel");

endmodule

bind clipped_ellipse_brush_scan_core cebs_checker u_cebs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== tb/clipped_ellipse_brush_scan_core_test.sv =====
// ----------------------------------------------------------------------------
// clipped_ellipse_brush_scan_core_test
// Drives brush stamps and scan advances into the ellipse brush scanner under
// a range of image sizes and terrain extents. An in-bench texel predictor
// follows every accepted item and each returned texel is checked field by
// field, with random idling on both streams.
// ----------------------------------------------------------------------------
module clipped_ellipse_brush_scan_core_test;
	import cebs_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int SETTLE      = 100;
	localparam int ITEM_TARGET = 1450;

	typedef struct {
		logic [PIX_W-1:0]    px;
		logic [PIX_W-1:0]    py;
		logic [ADDR_W-1:0]   addr;
		logic [COLOUR_W-1:0] value;
		logic                we;
		logic                live;
		logic                fin;
	} texel_t;

	class brush_scan_tracker;
		logic [DIM_W-1:0]    width_reg;
		logic [DIM_W-1:0]    height_reg;
		logic [TS_W-1:0]     terrain_reg;
		logic [CTR_W-1:0]    ctr_x;
		logic [CTR_W-1:0]    ctr_y;
		logic [AXIS_W-1:0]   axis_w;
		logic [AXIS_W-1:0]   axis_h;
		logic [DIM_W-1:0]    col;
		logic [DIM_W-1:0]    row;
		logic [COLOUR_W-1:0] colour;
		bit                  active;
		texel_t              texels_due[$];
		int                  mismatches;

		function new();
			width_reg   = WIDTH_RESET;
			height_reg  = HEIGHT_RESET;
			terrain_reg = TERRAIN_RESET;
			ctr_x       = '0;
			ctr_y       = '0;
			axis_w      = '0;
			axis_h      = '0;
			col         = '0;
			row         = '0;
			colour      = '0;
			active      = 1'b0;
			mismatches  = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_WIDTH: width_reg = val[DIM_W-1:0];
				REG_HEIGHT: height_reg = val[DIM_W-1:0];
				REG_TERRAIN: terrain_reg = val[TS_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp_dim(logic [DIM_W-1:0] r);
			return (r > MAX_DIM) ? longint'(MAX_DIM) : longint'(r);
		endfunction

		function longint scale(logic [COORD_W-1:0] v, longint dim, longint sat);
			longint q;
			q = longint'(v) * dim / longint'(terrain_reg);
			return (q > sat) ? sat : q;
		endfunction

		function void clip(longint c, longint a, longint dim, output longint lo,
				output longint hi);
			lo = (c - a < 0) ? 0 : c - a;
			hi = (c + a > dim) ? dim : c + a;
		endfunction

		function void start_stamp(logic [IN_TDATA_W-1:0] d);
			longint w, h, left, right, top, bottom;
			w = clamp_dim(width_reg);
			h = clamp_dim(height_reg);
			active = 1'b0;
			colour = d[3*COORD_W +: COLOUR_W];
			if (terrain_reg == '0)
				return;
			ctr_x  = CTR_W'(scale(d[COORD_W-1:0], w, longint'(CENTER_SAT)));
			ctr_y  = CTR_W'(scale(d[COORD_W +: COORD_W], h, longint'(CENTER_SAT)));
			axis_w = AXIS_W'(scale(d[2*COORD_W +: COORD_W], w, longint'(AXIS_SAT)));
			axis_h = AXIS_W'(scale(d[2*COORD_W +: COORD_W], h, longint'(AXIS_SAT)));
			if (axis_w == '0 || axis_h == '0)
				return;
			clip(longint'(ctr_x), longint'(axis_w), w, left, right);
			clip(longint'(ctr_y), longint'(axis_h), h, top, bottom);
			if (left >= w || top >= h || right <= 0 || bottom <= 0)
				return;
			col    = DIM_W'(left);
			row    = DIM_W'(top);
			active = 1'b1;
		endfunction

		function void take_item(logic cmd, logic [IN_TDATA_W-1:0] d);
			texel_t t;
			longint w, h, left, right, top, bottom, dx, dy, aw, ah, c, r;
			bit row_end;
			if (cmd == CMD_START) begin
				start_stamp(d);
				return;
			end
			t = '{default: '0};
			if (active) begin
				w = clamp_dim(width_reg);
				h = clamp_dim(height_reg);
				clip(longint'(ctr_x), longint'(axis_w), w, left, right);
				clip(longint'(ctr_y), longint'(axis_h), h, top, bottom);
				c  = longint'(col);
				r  = longint'(row);
				dx = (c > longint'(ctr_x)) ? c - longint'(ctr_x) : longint'(ctr_x) - c;
				dy = (r > longint'(ctr_y)) ? r - longint'(ctr_y) : longint'(ctr_y) - r;
				aw = longint'(axis_w) * longint'(axis_w);
				ah = longint'(axis_h) * longint'(axis_h);
				row_end = (r + 1 >= bottom);
				t.px    = c[PIX_W-1:0];
				t.py    = r[PIX_W-1:0];
				t.addr  = ADDR_W'(r * w + c);
				t.we    = (dx * dx * ah + dy * dy * aw < aw * ah);
				t.value = t.we ? colour : '0;
				t.live  = 1'b1;
				t.fin   = row_end && (c + 1 >= right);
				if (t.fin) begin
					active = 1'b0;
				end else if (row_end) begin
					row = DIM_W'(top);
					col = col + 1'b1;
				end else begin
					row = row + 1'b1;
				end
			end
			texels_due.push_back(t);
		endfunction

		task report(string msg);
			mismatches++;
			$display("%0t mismatch: %s", $time, msg);
		endtask

		task compare(string name, longint got, longint want);
			if (got != want)
				report($sformatf("%s got %0h want %0h", name, got, want));
		endtask

		task check_texel(logic [OUT_TDATA_W-1:0] d, logic tl);
			texel_t t;
			if (texels_due.size() == 0) begin
				report($sformatf("texel item with nothing due, data %h", d));
				return;
			end
			t = texels_due.pop_front();
			compare("pixel_x", d[11:0], t.px);
			compare("pixel_y", d[23:12], t.py);
			compare("pixel_address", d[47:24], t.addr);
			compare("pixel_value", d[79:48], t.value);
			compare("write_enable", d[80], t.we);
			compare("scan_valid", d[81], t.live);
			compare("last", tl, t.fin);
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [REG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                  m_tlast;

	brush_scan_tracker tracker;
	bit                quiet = 1'b0;
	int                sent = 0;
	int                stalled = 0;

	clipped_ellipse_brush_scan_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stalled <= 0;
		else
			stalled <= stalled + 1;
	end

	initial begin
		while (stalled < IDLE_LIMIT)
			@(posedge clk);
		$display("clipped_ellipse_brush_scan_core_test NOT OK");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_dim();
		logic [DIM_W-1:0] d;
		case ($urandom_range(0, 15))
			0: d = '0;
			1: d = DIM_W'($urandom_range(4097, 8191));
			2, 3: d = DIM_W'($urandom_range(49, 4096));
			default: d = DIM_W'($urandom_range(1, 48));
		endcase
		return {11'($urandom), d};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_terrain();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return CFG_DATA_W'($urandom_range(1, 255));
			2: return CFG_DATA_W'($urandom_range(24'hF00000, 24'hFFFFFF));
			default: return CFG_DATA_W'($urandom_range(256, 24'hFFFFFF));
		endcase
	endfunction

	task automatic push_item(input logic cmd, input logic [IN_TDATA_W-1:0] d);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		tracker.take_item(cmd, d);
		sent++;
	endtask

	task automatic start_brush(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cz,
			input logic [COORD_W-1:0] rad, input logic [COLOUR_W-1:0] colour);
		push_item(CMD_START, {colour, rad, cz, cx});
	endtask

	task automatic step_scan(input int n);
		repeat (n)
			push_item(CMD_ADVANCE, IN_TDATA_W'({$urandom, $urandom, $urandom, $urandom}));
	endtask

	task automatic scan_stamp(input int cap);
		int n;
		n = 0;
		while (tracker.active && n < cap) begin
			step_scan(1);
			n++;
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.texels_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_put(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(idx, val);
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
			input logic [CFG_DATA_W-1:0] ts);
		cfg_put(REG_WIDTH, w);
		cfg_put(REG_HEIGHT, h);
		cfg_put(REG_TERRAIN, ts);
		cfg_valid <= 1'b0;
	endtask

	task automatic sink();
		int gap;
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			tracker.check_texel(m_tdata, m_tlast);
		end
	endtask

	task automatic random_phase(input int count);
		int goal, kind, cap;
		longint ts, dmax, reach, rad;
		goal = sent + count;
		while (sent < goal) begin
			kind = $urandom_range(0, 15);
			if (kind == 0) begin
				start_brush(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), $urandom);
				scan_stamp($urandom_range(0, 40));
			end else if (kind == 1) begin
				step_scan($urandom_range(1, 3));
			end else begin
				ts   = longint'(tracker.terrain_reg);
				dmax = tracker.clamp_dim(tracker.width_reg);
				if (tracker.clamp_dim(tracker.height_reg) > dmax)
					dmax = tracker.clamp_dim(tracker.height_reg);
				if (dmax == 0)
					dmax = 1;
				reach = ts + ts / 4;
				if (reach > 24'hFFFFFF)
					reach = 24'hFFFFFF;
				rad = ts * $urandom_range(0, 1792) / (256 * dmax);
				if (rad > 24'hFFFFFF)
					rad = 24'hFFFFFF;
				start_brush(COORD_W'($urandom_range(0, reach)), COORD_W'($urandom_range(0, reach)),
					COORD_W'(rad), $urandom);
				cap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : 300;
				scan_stamp(cap);
				if ($urandom_range(0, 3) == 0)
					step_scan($urandom_range(1, 2));
			end
		end
	endtask

	initial begin
		tracker = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			sink();
		join_none

		// idle advance under reset geometry
		step_scan(1);

		// saturated radius covers the whole tiny image
		drain();
		program_regs(2, 2, 512);
		start_brush('0, '0, 24'hFFFFFF, 32'hFFFF_FFFF);
		step_scan(4);

		// small stamp, replaced mid-scan by a corner stamp
		drain();
		program_regs(16, 16, 4096);
		start_brush(24'h000500, 24'h000500, 24'h000100, 32'h1234_5678);
		step_scan(2);
		start_brush('0, '0, 24'h000100, '0);
		step_scan(1);

		// centre far outside, then zero radius
		start_brush(24'hFFFFFF, 24'h000500, 24'h000100, 32'h5A5A_5A5A);
		step_scan(1);
		start_brush(24'h000500, 24'h000500, '0, 32'h0F0F_0F0F);
		step_scan(1);

		// shrink the image mid-stamp
		start_brush(24'h000500, 24'h000500, 24'h000100, 32'hA5A5_A5A5);
		step_scan(1);
		drain();
		program_regs(32, 5, 4096);
		step_scan(3);

		drain();
		program_regs(16, 16, 0);
		start_brush(24'h000500, 24'h000500, 24'h000100, 32'h8000_0001);
		step_scan(1);

		drain();
		program_regs(0, 16, 4096);
		start_brush(24'h000500, 24'h000500, 24'h000100, 32'h7FFF_FFFE);
		step_scan(1);

		// oversize registers clamp to the largest image
		drain();
		program_regs(8191, 8191, 24'hFFFFFF);
		start_brush(24'hFFFFFF, 24'hFFFFFF, 24'h001000, 32'hFFFF_FFFF);
		step_scan(1);

		while (sent < ITEM_TARGET) begin
			drain();
			program_regs(pick_dim(), pick_dim(), pick_terrain());
			quiet = ($urandom_range(0, 3) == 0);
			random_phase($urandom_range(60, 200));
		end

		s_tvalid <= 1'b0;
		while (tracker.texels_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("clipped_ellipse_brush_scan_core_test OK");
		else
			$display("clipped_ellipse_brush_scan_core_test NOT OK");
		$finish;
	end

endmodule

// ===== clipped_ellipse_brush_scan_core.f =====
hw/rtl/cebs_pkg.sv
hw/rtl/cebs_div.sv
hw/rtl/cebs_ctrl.sv
hw/rtl/cebs_dp.sv
hw/rtl/clipped_ellipse_brush_scan_core.sv
hw/rtl/cebs_checker.sv
tb/clipped_ellipse_brush_scan_core_test.sv
